// ----- src/greedy_balanced_owner_assign_core_defines.svh -----
// Assertion macros for the checker file of the owner assignment core.
// Depends on nothing; included by name where assertions are written.
`ifndef GREEDY_BALANCED_OWNER_ASSIGN_CORE_DEFINES_SVH
`define GREEDY_BALANCED_OWNER_ASSIGN_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define GBOA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, checked while out of reset.
`define GBOA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ----- src/gboa_pkg.sv -----
// Package of the owner assignment core: sizes, widths and register indexes.
// Depends on nothing; used by greedy_balanced_owner_assign_core, its checker and its testbench.
package gboa_pkg;

  localparam int unsigned MaxRanks  = 16;
  localparam int unsigned RankW     = $clog2(MaxRanks);
  localparam int unsigned CountW    = 5;
  localparam int unsigned ChunkW    = 32;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned RecordW   = 16;
  localparam int unsigned ScoreW    = 33;
  localparam int unsigned TotalW    = 48;
  localparam int unsigned MarginW   = 49;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned OwnerW    = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANK_COUNT   = 2'd0,
    CFG_CHUNK_SIZE   = 2'd1,
    CFG_SHARE_SHIFT  = 2'd2,
    CFG_RECORD_COUNT = 2'd3
  } cfg_reg_e;

  typedef logic [TotalW-1:0]         total_t;
  typedef logic signed [MarginW-1:0] margin_t;

endpackage

// ----- src/greedy_balanced_owner_assign_core.sv -----
// Owner assignment core: picks per chunk the rank with the largest score minus load.
// Depends on gboa_pkg.
//
//  channel   direction  signals                                  meaning of a beat
//  in        sink       in_valid_i/in_ready_o, overlap_score_i,  one rank score of a chunk
//                       first_of_batch_i
//  out       source     out_valid_o/out_ready_i, owner_rank_o,   owner of a finished chunk
//                       owner_margin_o
//  cfg       sink       cfg_we_i, cfg_idx_i, cfg_wdata_i         register write, no wait
//
// One score beat is taken per cycle unless a stalled result blocks input; the result of a
// chunk shows in the output register the cycle after its last score beat.
// The path per beat is one read of the load table at the current position, a 49-bit
// subtract and a signed compare against the running best.
// Reset (rst_ni low, asynchronous) clears all load totals, position and output valid.
// A waiting result stalls input only when out_ready_i is low.
module greedy_balanced_owner_assign_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [gboa_pkg::ScoreW-1:0]           overlap_score_i,
  input  logic                                  first_of_batch_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gboa_pkg::OwnerW-1:0]           owner_rank_o,
  output logic signed [gboa_pkg::MarginW-1:0]   owner_margin_o,
  input  logic                                  cfg_we_i,
  input  logic [gboa_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [gboa_pkg::CfgDataW-1:0]         cfg_wdata_i
);

  localparam int unsigned RankW  = gboa_pkg::RankW;
  localparam int unsigned CountW = gboa_pkg::CountW;
  localparam int unsigned TotalW = gboa_pkg::TotalW;

  // configuration registers
  logic [CountW-1:0]               rank_count_q, rank_count_d;
  logic [gboa_pkg::ChunkW-1:0]     chunk_size_q, chunk_size_d;
  logic [gboa_pkg::ShiftW-1:0]     share_shift_q, share_shift_d;
  logic [gboa_pkg::RecordW-1:0]    record_count_q, record_count_d;
  gboa_pkg::total_t                penalty_q, penalty_d;

  // chunk state
  gboa_pkg::total_t                load_q [gboa_pkg::MaxRanks];
  logic [RankW-1:0]                pos_q, pos_d;
  logic [RankW-1:0]                best_rank_q, best_rank_d;
  gboa_pkg::margin_t               best_margin_q, best_margin_d;
  gboa_pkg::total_t                best_load_q, best_load_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [gboa_pkg::OwnerW-1:0]     owner_rank_q;
  gboa_pkg::margin_t               owner_margin_q;

  logic                            accept;
  logic [CountW-1:0]               n_eff;
  logic [CountW-1:0]               pos_inc;
  logic                            finish;
  gboa_pkg::total_t                cur_load;
  gboa_pkg::total_t                prev_best_load;
  gboa_pkg::margin_t               margin;
  logic                            take;
  logic [TotalW:0]                 load_sum;
  gboa_pkg::total_t                new_load;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // config write decode; penalty follows the written values
  always_comb begin
    rank_count_d   = rank_count_q;
    chunk_size_d   = chunk_size_q;
    share_shift_d  = share_shift_q;
    record_count_d = record_count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gboa_pkg::CFG_RANK_COUNT:   rank_count_d   = cfg_wdata_i[CountW-1:0];
        gboa_pkg::CFG_CHUNK_SIZE:   chunk_size_d   = cfg_wdata_i[gboa_pkg::ChunkW-1:0];
        gboa_pkg::CFG_SHARE_SHIFT:  share_shift_d  = cfg_wdata_i[gboa_pkg::ShiftW-1:0];
        gboa_pkg::CFG_RECORD_COUNT: record_count_d = cfg_wdata_i[gboa_pkg::RecordW-1:0];
        default: ;
      endcase
    end
    penalty_d = TotalW'(chunk_size_d >> share_shift_d) * TotalW'(record_count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q   <= CountW'(1);
      chunk_size_q   <= '0;
      share_shift_q  <= '0;
      record_count_q <= gboa_pkg::RecordW'(1);
      penalty_q      <= '0;
    end else begin
      rank_count_q   <= rank_count_d;
      chunk_size_q   <= chunk_size_d;
      share_shift_q  <= share_shift_d;
      record_count_q <= record_count_d;
      penalty_q      <= penalty_d;
    end
  end

  // effective rank count: zero acts as one, capped at the table size
  always_comb begin
    n_eff = rank_count_q;
    if (rank_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (rank_count_q > CountW'(gboa_pkg::MaxRanks)) begin
      n_eff = CountW'(gboa_pkg::MaxRanks);
    end
  end

  // per-beat score step
  always_comb begin
    cur_load       = first_of_batch_i ? '0 : load_q[pos_q];
    prev_best_load = first_of_batch_i ? '0 : best_load_q;
    margin         = gboa_pkg::margin_t'({16'd0, overlap_score_i})
                   - gboa_pkg::margin_t'({1'b0, cur_load});
    take           = (pos_q == '0) || (margin > best_margin_q);
    best_rank_d    = take ? pos_q : best_rank_q;
    best_margin_d  = take ? margin : best_margin_q;
    best_load_d    = take ? cur_load : prev_best_load;
    pos_inc        = CountW'(pos_q) + CountW'(1);
    finish         = pos_inc >= n_eff;
    pos_d          = finish ? '0 : pos_inc[RankW-1:0];
    // owner load update, saturating at the top of the range
    load_sum       = {1'b0, best_load_d} + {1'b0, penalty_q};
    new_load       = load_sum[TotalW] ? '1 : load_sum[TotalW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      best_rank_q   <= '0;
      best_margin_q <= '0;
      best_load_q   <= '0;
    end else if (accept) begin
      pos_q         <= pos_d;
      best_rank_q   <= best_rank_d;
      best_margin_q <= best_margin_d;
      best_load_q   <= best_load_d;
    end
  end

  // load table: batch clear, then owner update at chunk end
  for (genvar r = 0; r < gboa_pkg::MaxRanks; r++) begin : g_load
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        load_q[r] <= '0;
      end else if (accept) begin
        if (finish && (best_rank_d == RankW'(r))) begin
          load_q[r] <= new_load;
        end else if (first_of_batch_i) begin
          load_q[r] <= '0;
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && finish) begin
      owner_rank_q   <= gboa_pkg::OwnerW'(best_rank_d);
      owner_margin_q <= best_margin_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign owner_rank_o   = owner_rank_q;
  assign owner_margin_o = owner_margin_q;

endmodule

// ----- src/gboa_checker.sv -----
// Port checker for greedy_balanced_owner_assign_core, bound into every instance of the core.
// Depends on gboa_pkg and greedy_balanced_owner_assign_core_defines.svh.
`include "greedy_balanced_owner_assign_core_defines.svh"

module gboa_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [gboa_pkg::OwnerW-1:0]           owner_rank_o,
  input logic signed [gboa_pkg::MarginW-1:0]   owner_margin_o
);

  // a waiting result beat holds until taken
  `GBOA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a stalled result keeps its payload
  `GBOA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(owner_rank_o) && $stable(owner_margin_o))

  // input stalls only behind a blocked result
  `GBOA_ASSERT_IMPL(a_in_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a new result only follows an accepted score beat
  `GBOA_ASSERT_IMPL(a_out_cause, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o))

endmodule

bind greedy_balanced_owner_assign_core gboa_checker u_gboa_checker (.*);

// ----- test/greedy_balanced_owner_assign_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench of greedy_balanced_owner_assign_core: streams rank score beats under changing
// register settings, predicts each chunk's owner and margin, and checks every owner beat.
// Depends on gboa_pkg and greedy_balanced_owner_assign_core.

typedef struct {
  logic [gboa_pkg::OwnerW-1:0]         rank;
  logic signed [gboa_pkg::MarginW-1:0] margin;
} owner_beat_t;

// Tracks register values and load totals, and queues the owner each finished chunk gets
class owner_predictor;
  logic [gboa_pkg::CountW-1:0]  rank_count;
  logic [gboa_pkg::ChunkW-1:0]  chunk_size;
  logic [gboa_pkg::ShiftW-1:0]  share_shift;
  logic [gboa_pkg::RecordW-1:0] record_count;
  logic [gboa_pkg::TotalW-1:0]  load_total [gboa_pkg::MaxRanks];
  int unsigned                  position;
  int unsigned                  best_rank;
  longint                       best_margin;
  owner_beat_t                  expected_owners [$];
  int unsigned                  mismatches;
  int unsigned                  beats;
  int unsigned                  owners_seen;

  function new();
    rank_count   = 1;
    chunk_size   = '0;
    share_shift  = '0;
    record_count = 1;
    foreach (load_total[i]) load_total[i] = '0;
    position    = 0;
    best_rank   = 0;
    best_margin = 0;
    mismatches  = 0;
    beats       = 0;
    owners_seen = 0;
  endfunction

  function void write_reg(gboa_pkg::cfg_reg_e idx, logic [gboa_pkg::CfgDataW-1:0] value);
    case (idx)
      gboa_pkg::CFG_RANK_COUNT:   rank_count   = value[gboa_pkg::CountW-1:0];
      gboa_pkg::CFG_CHUNK_SIZE:   chunk_size   = value[gboa_pkg::ChunkW-1:0];
      gboa_pkg::CFG_SHARE_SHIFT:  share_shift  = value[gboa_pkg::ShiftW-1:0];
      gboa_pkg::CFG_RECORD_COUNT: record_count = value[gboa_pkg::RecordW-1:0];
      default: ;
    endcase
  endfunction

  // zero counts as one rank, anything past the table size as the full table
  function int unsigned chunk_ranks();
    int unsigned n;
    n = rank_count;
    if (n == 0) n = 1;
    if (n > gboa_pkg::MaxRanks) n = gboa_pkg::MaxRanks;
    return n;
  endfunction

  function int unsigned pending();
    return expected_owners.size();
  endfunction

  // One accepted score beat
  function void note_score(logic [gboa_pkg::ScoreW-1:0] score, logic clear);
    int unsigned n;
    int unsigned pos;
    longint      margin;
    logic [63:0] penalty;
    logic [63:0] raised;
    logic [63:0] ceiling;
    owner_beat_t due;
    n   = chunk_ranks();
    pos = (position >= gboa_pkg::MaxRanks) ? gboa_pkg::MaxRanks - 1 : position;
    beats++;
    // batch flag wipes the totals only; position and running best stay
    if (clear) foreach (load_total[i]) load_total[i] = '0;
    margin = $signed({31'd0, score}) - $signed({16'd0, load_total[pos]});
    // strict compare: a tie keeps the lower rank
    if (pos == 0 || margin > best_margin) begin
      best_rank   = pos;
      best_margin = margin;
    end
    pos++;
    // a lowered rank count finishes the chunk as soon as the position reaches it
    if (pos >= n) begin
      ceiling = (64'd1 << gboa_pkg::TotalW) - 64'd1;
      penalty = {32'd0, chunk_size >> share_shift} * {48'd0, record_count};
      raised  = {16'd0, load_total[best_rank]} + penalty;
      if (raised > ceiling) raised = ceiling;
      due.rank   = best_rank[gboa_pkg::OwnerW-1:0];
      due.margin = best_margin[gboa_pkg::MarginW-1:0];
      expected_owners.push_back(due);
      load_total[best_rank] = raised[gboa_pkg::TotalW-1:0];
      position = 0;
    end else begin
      position = pos;
    end
  endfunction

  // One accepted owner beat against the oldest expectation
  function void check_owner(logic [gboa_pkg::OwnerW-1:0] rank,
                            logic signed [gboa_pkg::MarginW-1:0] margin);
    owner_beat_t due;
    owners_seen++;
    if (expected_owners.size() == 0) begin
      $display("%0t: owner beat with none expected: rank %0d margin %0d", $time, rank, margin);
      mismatches++;
      return;
    end
    due = expected_owners.pop_front();
    if (rank !== due.rank) begin
      $display("%0t: owner_rank expected %0d actual %0d", $time, due.rank, rank);
      mismatches++;
    end
    if (margin !== due.margin) begin
      $display("%0t: owner_margin expected %0d actual %0d", $time, due.margin, margin);
      mismatches++;
    end
  endfunction
endclass

module greedy_balanced_owner_assign_core_tb;

  localparam int unsigned ScoreW   = gboa_pkg::ScoreW;
  localparam int unsigned OwnerW   = gboa_pkg::OwnerW;
  localparam int unsigned MarginW  = gboa_pkg::MarginW;
  localparam int unsigned CfgDataW = gboa_pkg::CfgDataW;
  localparam int unsigned CountW   = gboa_pkg::CountW;
  localparam int unsigned ChunkW   = gboa_pkg::ChunkW;
  localparam int unsigned ShiftW   = gboa_pkg::ShiftW;
  localparam int unsigned RecordW  = gboa_pkg::RecordW;
  localparam int unsigned MaxRanks = gboa_pkg::MaxRanks;

  localparam int unsigned StallLimit      = 2000;
  localparam int unsigned DrainCycles     = 4;
  localparam int unsigned ItemsPerPhase   = 165;
  localparam int unsigned ItemsPerSetting = 40;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [ScoreW-1:0]    overlap_score  = '0;
  logic                 first_of_batch = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [OwnerW-1:0]    owner_rank;
  logic signed [MarginW-1:0] owner_margin;
  logic                 cfg_we         = 1'b0;
  gboa_pkg::cfg_reg_e   cfg_idx        = gboa_pkg::CFG_RANK_COUNT;
  logic [CfgDataW-1:0]  cfg_wdata      = '0;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 82;
  int unsigned stall_cycles  = 0;
  int unsigned settings_used = 0;
  owner_predictor owners;

  greedy_balanced_owner_assign_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .overlap_score_i  (overlap_score),
    .first_of_batch_i (first_of_batch),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .owner_rank_o     (owner_rank),
    .owner_margin_o   (owner_margin),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Handshakes are sampled mid-cycle, where both sides are settled; watchdog alongside
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) owners.check_owner(owner_rank, owner_margin);
      if (in_valid && in_ready) owners.note_score(overlap_score, first_of_batch);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // One score beat; valid stays up from the previous beat unless the sender idles
  task automatic send_score(input logic [ScoreW-1:0] score, input logic clear);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    overlap_score  <= score;
    first_of_batch <= clear;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Sender holds off until every owner beat is back, plus the core's own latency
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (owners.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CountW-1:0] ranks, input logic [ChunkW-1:0] size,
                              input logic [ShiftW-1:0] shift,
                              input logic [RecordW-1:0] records);
    gboa_pkg::cfg_reg_e  idx [4];
    logic [CfgDataW-1:0] data [4];
    idx  = '{gboa_pkg::CFG_RANK_COUNT, gboa_pkg::CFG_CHUNK_SIZE, gboa_pkg::CFG_SHARE_SHIFT,
             gboa_pkg::CFG_RECORD_COUNT};
    data = '{CfgDataW'(ranks), CfgDataW'(size), CfgDataW'(shift), CfgDataW'(records)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= data[i];
      owners.write_reg(idx[i], data[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly small scores so that load totals matter; edges and full range mixed in
  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2:          return {1'b1, 32'h0};
      3, 4, 5, 6: return ScoreW'($urandom_range(511));
      default:    return {1'($urandom_range(1)), 32'($urandom())};
    endcase
  endfunction

  task automatic random_setting();
    logic [CountW-1:0]  ranks;
    logic [ChunkW-1:0]  size;
    logic [ShiftW-1:0]  shift;
    logic [RecordW-1:0] records;
    case ($urandom_range(9))
      0:       ranks = '0;
      1:       ranks = '1;
      2:       ranks = CountW'(MaxRanks);
      3:       ranks = CountW'($urandom_range(30, 17));
      4:       ranks = CountW'(1);
      default: ranks = CountW'($urandom_range(8, 2));
    endcase
    case ($urandom_range(5))
      0:       size = '0;
      1:       size = '1;
      2:       size = $urandom();
      default: size = ChunkW'($urandom_range(64));
    endcase
    case ($urandom_range(5))
      0:       shift = '0;
      1:       shift = '1;
      default: shift = ShiftW'($urandom_range(4));
    endcase
    case ($urandom_range(5))
      0:       records = '0;
      1:       records = '1;
      default: records = RecordW'($urandom_range(8, 1));
    endcase
    program_regs(ranks, size, shift, records);
  endtask

  // Mostly whole chunks with random scores; some cut short so a new setting lands mid-chunk
  task automatic run_random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned in_setting;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      wait_drain();
      random_setting();
      in_setting = 0;
      while (in_setting < ItemsPerSetting && sent < items) begin
        len = owners.chunk_ranks();
        len = (owners.position < len) ? len - owners.position : 1;
        if ($urandom_range(7) == 0) len = $urandom_range(len, 1);
        repeat (len) begin
          send_score(pick_score(), ($urandom_range(15) == 0));
          sent++;
          in_setting++;
        end
        // one full hold-off halfway through the phase
        if (sent >= items / 2 && sent - len < items / 2) wait_drain();
      end
    end
  endtask

  initial begin
    owners = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: one rank, no penalty
    send_score('0, 1'b0);
    send_score('1, 1'b0);
    wait_drain();

    // zero rank count acts as one; largest penalty drives rank 0 into saturation
    program_regs('0, '1, '0, '1);
    send_score(ScoreW'(5), 1'b0);
    send_score('0, 1'b0);
    send_score('0, 1'b0);
    send_score({1'b1, 32'h0}, 1'b1);
    wait_drain();

    // three ranks, penalty 4: a tie between ranks 1 and 2, a clear winner, batch flag mid-chunk
    program_regs(CountW'(3), ChunkW'(16), ShiftW'(2), RecordW'(1));
    repeat (3) send_score(ScoreW'(7), 1'b0);
    send_score(ScoreW'(10), 1'b0);
    send_score(ScoreW'(14), 1'b0);
    send_score(ScoreW'(14), 1'b0);
    send_score('0, 1'b0);
    send_score('0, 1'b1);
    send_score('0, 1'b0);
    wait_drain();

    // rank count lowered below the position of an open chunk
    program_regs(CountW'(5), ChunkW'(16), ShiftW'(2), RecordW'(1));
    send_score(ScoreW'(3), 1'b0);
    send_score(ScoreW'(9), 1'b0);
    send_score(ScoreW'(9), 1'b0);
    wait_drain();
    program_regs(CountW'(2), 32'h8000_0000, '1, RecordW'(3));
    send_score(ScoreW'(12), 1'b0);

    run_random_phase(ItemsPerPhase);

    send_idle_pct = 82;
    recv_idle_pct = 6;
    run_random_phase(ItemsPerPhase);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(ItemsPerPhase);

    wait_drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d owner beats from %0d score beats across %0d register settings,",
             owners.owners_seen, owners.beats, settings_used);
    $display("with sender and receiver stalling in turn and then running back to back.");
    if (owners.mismatches == 0 && owners.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
